// File: rtl/gilinv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gilinv_pkg;

   // Field word width and the number of working slots carried along the chain.
   localparam int WordBits = 64;
   localparam int HalfBits = WordBits / 2;
   localparam int NumSlots = 8;
   localparam int SelBits  = $clog2(NumSlots);

   // Number of Montgomery products in the addition chain, one cell each.
   localparam int NumOps = 72;

   // Slot codes.
   localparam logic [SelBits-1:0] SLOT_ACC = 3'd0;
   localparam logic [SelBits-1:0] SLOT_X   = 3'd1;
   localparam logic [SelBits-1:0] SLOT_T1  = 3'd2;
   localparam logic [SelBits-1:0] SLOT_T2  = 3'd3;
   localparam logic [SelBits-1:0] SLOT_T3  = 3'd4;
   localparam logic [SelBits-1:0] SLOT_T4  = 3'd5;
   localparam logic [SelBits-1:0] SLOT_T6  = 3'd6;
   localparam logic [SelBits-1:0] SLOT_LO  = 3'd7;

   typedef logic [NumSlots-1:0][WordBits-1:0] slots_type;

   // What travels from one cell to the next.
   typedef struct packed {
      logic      valid;
      slots_type slots;
   } stage_type;

   // The fixed operation of one cell: operand slots and the slots the product is written to.
   typedef struct packed {
      logic [SelBits-1:0]  a_sel;
      logic [SelBits-1:0]  b_sel;
      logic [NumSlots-1:0] dst_mask;
   } op_type;

   function automatic logic [NumSlots-1:0] slot_bit(input logic [SelBits-1:0] s);
      logic [NumSlots-1:0] m;
      m = '0;
      m[s] = 1'b1;
      return m;
   endfunction

   // Operation of chain position idx in the inverse-of-seven addition chain.
   function automatic op_type get_op(input int idx);
      op_type o;
      o.a_sel    = SLOT_ACC;
      o.b_sel    = SLOT_ACC;
      o.dst_mask = slot_bit(SLOT_ACC);
      priority if (idx == 0) begin
         o.dst_mask = slot_bit(SLOT_ACC) | slot_bit(SLOT_T1);
      end else if (idx == 1) begin
         o.dst_mask = slot_bit(SLOT_ACC) | slot_bit(SLOT_T2);
      end else if (idx == 5) begin
         o.b_sel    = SLOT_T2;
         o.dst_mask = slot_bit(SLOT_ACC) | slot_bit(SLOT_T3);
      end else if (idx == 12) begin
         o.b_sel    = SLOT_T3;
         o.dst_mask = slot_bit(SLOT_ACC) | slot_bit(SLOT_T4);
      end else if (idx == 25) begin
         o.b_sel    = SLOT_T4;
      end else if (idx == 32) begin
         o.b_sel    = SLOT_T3;
         o.dst_mask = slot_bit(SLOT_ACC) | slot_bit(SLOT_T6);
      end else if (idx == 64 || idx == 66) begin
         o.b_sel    = SLOT_T6;
      end else if (idx == 69) begin
         o.a_sel    = SLOT_T1;
         o.b_sel    = SLOT_T2;
         o.dst_mask = slot_bit(SLOT_LO);
      end else if (idx == 70) begin
         o.a_sel    = SLOT_LO;
         o.b_sel    = SLOT_X;
         o.dst_mask = slot_bit(SLOT_LO);
      end else if (idx == 71) begin
         o.b_sel    = SLOT_LO;
      end else begin
         o.dst_mask = slot_bit(SLOT_ACC);
      end
      return o;
   endfunction

endpackage
`default_nettype wire

// File: rtl/goldilocks_inverse_sbox.sv
// A request passes through 72 cells of three stages each (set by the 72
// Montgomery products of the addition chain) and then the output register.
// Throughput: one element per cycle when not stalled; each cell holds one product in flight per stage.
// Reset clears all valid flags synchronously; the data path is not reset.
`timescale 1ns / 1ps
`default_nettype none
module goldilocks_inverse_sbox
   import gilinv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [WordBits-1:0] req_element_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [WordBits-1:0]      rsp_element_out
);

   stage_type chain [NumOps+1];
   logic      pipe_en;

   // Every slot starts as the input element; the chain overwrites them in turn.
   assign chain[0].valid = req_valid;
   assign chain[0].slots = {NumSlots{req_element_in}};
   assign req_stall      = !pipe_en;

   // One cell for each product of the addition chain.
   for (genvar g = 0; g < NumOps; g++) begin : g_cell
      gilinv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .op        (get_op(g)),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   // Response register and skid entry.
   gilinv_out u_out (
      .clock           (clock),
      .reset           (reset),
      .pipe_valid      (chain[NumOps].valid),
      .pipe_data       (chain[NumOps].slots[SLOT_ACC]),
      .pipe_en         (pipe_en),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_element_out (rsp_element_out)
   );

endmodule
`default_nettype wire

// File: rtl/gilinv_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module gilinv_cell
   import gilinv_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      en,
   input  wire op_type    op,
   input  wire stage_type stage_in,
   output stage_type      stage_out
);

   // Stage one: the four 32 x 32 partial products.
   logic [WordBits-1:0] a_word, b_word;
   logic [WordBits-1:0] p00_in, p01_in, p10_in, p11_in;
   logic [WordBits-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   stage_type           s1_ff;

   assign a_word = stage_in.slots[op.a_sel];
   assign b_word = stage_in.slots[op.b_sel];
   assign p00_in = WordBits'(a_word[HalfBits-1:0]) * WordBits'(b_word[HalfBits-1:0]);
   assign p01_in = WordBits'(a_word[HalfBits-1:0]) * WordBits'(b_word[WordBits-1:HalfBits]);
   assign p10_in = WordBits'(a_word[WordBits-1:HalfBits]) * WordBits'(b_word[HalfBits-1:0]);
   assign p11_in = WordBits'(a_word[WordBits-1:HalfBits]) * WordBits'(b_word[WordBits-1:HalfBits]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff.valid <= stage_in.valid;
      end
      if (en) begin
         s1_ff.slots <= stage_in.slots;
         p00_ff      <= p00_in;
         p01_ff      <= p01_in;
         p10_ff      <= p10_in;
         p11_ff      <= p11_in;
      end
   end

   // Stage two: gather the partial products into the 128-bit product.
   logic [HalfBits+1:0] mid;
   logic [WordBits-1:0] hi_in, lo_in, hi_ff, lo_ff;
   stage_type           s2_ff;

   assign mid   = (HalfBits+2)'(p00_ff[WordBits-1:HalfBits])
                + (HalfBits+2)'(p01_ff[HalfBits-1:0])
                + (HalfBits+2)'(p10_ff[HalfBits-1:0]);
   assign lo_in = {mid[HalfBits-1:0], p00_ff[HalfBits-1:0]};
   assign hi_in = p11_ff + WordBits'(p01_ff[WordBits-1:HalfBits])
                + WordBits'(p10_ff[WordBits-1:HalfBits]) + WordBits'(mid[HalfBits+1:HalfBits]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (en) begin
         s2_ff.valid <= s1_ff.valid;
      end
      if (en) begin
         s2_ff.slots <= s1_ff.slots;
         hi_ff       <= hi_in;
         lo_ff       <= lo_in;
      end
   end

   // Stage three: Montgomery reduction and write-back into the chosen slots.
   logic [WordBits:0]   sum;
   logic [WordBits-1:0] a_red, b_red, r_red, res;
   logic                borrow;
   stage_type           s3_in, s3_ff;

   always_comb begin
      sum    = {1'b0, lo_ff} + {1'b0, lo_ff[HalfBits-1:0], {HalfBits{1'b0}}};
      a_red  = sum[WordBits-1:0];
      b_red  = a_red - (a_red >> HalfBits) - WordBits'(sum[WordBits]);
      borrow = hi_ff < b_red;
      r_red  = hi_ff - b_red;
      res    = r_red - (borrow ? WordBits'({HalfBits{1'b1}}) : '0);
      s3_in  = s2_ff;
      for (int k = 0; k < NumSlots; k++) begin
         if (op.dst_mask[k]) begin
            s3_in.slots[k] = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (en) begin
         s3_ff.valid <= s3_in.valid;
      end
      if (en) begin
         s3_ff.slots <= s3_in.slots;
      end
   end

   assign stage_out = s3_ff;

endmodule
`default_nettype wire

// File: rtl/gilinv_out.sv
`timescale 1ns / 1ps
`default_nettype none
module gilinv_out
   import gilinv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pipe_valid,
   input  wire logic [WordBits-1:0] pipe_data,
   output logic                     pipe_en,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [WordBits-1:0]      rsp_element_out
);

   logic                valid_ff, skid_valid_ff;
   logic [WordBits-1:0] data_ff, skid_ff;
   logic                take;

   // The chain moves only while the skid register is free.
   assign take    = valid_ff && !rsp_stall;
   assign pipe_en = !skid_valid_ff;

   // Output register with one skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (pipe_valid) begin
         if (!valid_ff || take) begin
            valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         valid_ff <= 1'b0;
      end
      if (skid_valid_ff) begin
         if (take) begin
            data_ff <= skid_ff;
         end
      end else if (pipe_valid) begin
         if (!valid_ff || take) begin
            data_ff <= pipe_data;
         end else begin
            skid_ff <= pipe_data;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_element_out = data_ff;

endmodule
`default_nettype wire

// File: rtl/gilinv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module gilinv_checker
   import gilinv_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic [WordBits-1:0] req_element_in,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [WordBits-1:0] rsp_element_out
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // A stalled response keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_element_out))
      else $error("response changed while stalled");

   // A stalled request stays offered with the same element.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_element_in))
      else $error("request withdrawn or changed while stalled");

   // Reset leaves no response on offer.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

   // Requests are held back only while a response waits to be taken.
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

endmodule

bind goldilocks_inverse_sbox gilinv_checker u_gilinv_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_element_in  (req_element_in),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_element_out (rsp_element_out)
);
`default_nettype wire
